FILE: rtl/core/mbdt_pkg.sv
package mbdt_pkg;

  localparam int FC_W   = 8;
  localparam int ADDR_W = 16;
  localparam int QTY_W  = 10;
  localparam int DATA_W = 16;
  localparam int ST_W   = 2;
  localparam int NT_W   = 2;
  localparam int LEN_W  = 11;
  localparam int CFG_IDX_W = 2;

  // Wide enough for an offset plus a quantity and for any window length.
  localparam int CMP_W = 18;

  localparam int STORE_DEPTH_DEF  = 1024;
  localparam int MAX_READ_RESULTS = 64;

  localparam logic [QTY_W-1:0] ELEM_MAX = '1;

  // Function codes.
  localparam logic [FC_W-1:0] FC_RD_COILS  = 8'd1;
  localparam logic [FC_W-1:0] FC_RD_INPUTS = 8'd2;
  localparam logic [FC_W-1:0] FC_RD_HOLD   = 8'd3;
  localparam logic [FC_W-1:0] FC_RD_INREG  = 8'd4;
  localparam logic [FC_W-1:0] FC_WR_COIL   = 8'd5;
  localparam logic [FC_W-1:0] FC_WR_REG    = 8'd6;
  localparam logic [FC_W-1:0] FC_WR_COILS  = 8'd15;
  localparam logic [FC_W-1:0] FC_WR_REGS   = 8'd16;

  // Node types.
  localparam logic [NT_W-1:0] NT_COILS  = 2'd0;
  localparam logic [NT_W-1:0] NT_INPUTS = 2'd1;
  localparam logic [NT_W-1:0] NT_HOLD   = 2'd2;
  localparam logic [NT_W-1:0] NT_INREG  = 2'd3;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_ILL_FN   = 2'd1;
  localparam logic [ST_W-1:0] ST_ILL_ADDR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 2'd2;

  typedef struct packed {
    logic [NT_W-1:0]   node_type;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  data_length;
  } cfg_t;

  function automatic logic fc_legal(input logic [NT_W-1:0] nt, input logic [FC_W-1:0] fc);
    logic ok;
    case (nt)
      NT_COILS:  ok = (fc == FC_RD_COILS) || (fc == FC_WR_COIL) || (fc == FC_WR_COILS);
      NT_INPUTS: ok = (fc == FC_RD_INPUTS);
      NT_HOLD:   ok = (fc == FC_RD_HOLD) || (fc == FC_WR_REG) || (fc == FC_WR_REGS);
      NT_INREG:  ok = (fc == FC_RD_INREG);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/core/mbdt_ifs.sv
interface mbdt_in_if;
  logic                          valid;
  logic                          ready;
  logic [mbdt_pkg::FC_W-1:0]     req_type;
  logic [mbdt_pkg::ADDR_W-1:0]   address;
  logic [mbdt_pkg::QTY_W-1:0]    quantity;
  logic [mbdt_pkg::DATA_W-1:0]   value;
  logic                          last_element;

  modport source (output valid, req_type, address, quantity, value, last_element,
                  input ready);
  modport sink (input valid, req_type, address, quantity, value, last_element,
                output ready);
endinterface

interface mbdt_out_if;
  logic                          valid;
  logic                          ready;
  logic [mbdt_pkg::ST_W-1:0]     status;
  logic [mbdt_pkg::DATA_W-1:0]   data_word;
  logic                          last_result;

  modport source (output valid, status, data_word, last_result, input ready);
  modport sink (input valid, status, data_word, last_result, output ready);
endinterface

FILE: rtl/core/mbdt_store.sv
module mbdt_store #(
  parameter int STORE_DEPTH = mbdt_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  input  logic [mbdt_pkg::DATA_W-1:0]   wr_data,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  output logic [mbdt_pkg::DATA_W-1:0]   rd_data,
  output logic                          clr_busy
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [mbdt_pkg::DATA_W-1:0] mem [STORE_DEPTH];
  logic [mbdt_pkg::DATA_W-1:0] rd_data_r;
  logic                        clr_busy_r;
  logic [AW-1:0]               clr_addr_r;

  // After reset every entry is swept to zero, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(STORE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

FILE: rtl/core/mbdt_ctrl.sv
module mbdt_ctrl #(
  parameter int STORE_DEPTH = mbdt_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mbdt_pkg::cfg_t                 cfg,
  input  logic                           clr_busy,
  mbdt_in_if.sink                        in_req,
  mbdt_out_if.source                     out_rsp,
  output logic                           mem_we,
  output logic [$clog2(STORE_DEPTH)-1:0] mem_waddr,
  output logic [mbdt_pkg::DATA_W-1:0]    mem_wdata,
  output logic [$clog2(STORE_DEPTH)-1:0] mem_raddr,
  input  logic [mbdt_pkg::DATA_W-1:0]    mem_rdata
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CMP_W = mbdt_pkg::CMP_W;
  localparam int QTY_W = mbdt_pkg::QTY_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHK    = 3'd1;
  localparam logic [2:0] S_EMIT   = 3'd2;
  localparam logic [2:0] S_RD_ISS = 3'd3;
  localparam logic [2:0] S_RD_ACC = 3'd4;
  localparam logic [2:0] S_RD_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [mbdt_pkg::FC_W-1:0]   fc_r, fc_nxt;
  logic [QTY_W-1:0]            qty_r, qty_nxt;
  logic [mbdt_pkg::DATA_W-1:0] val_r, val_nxt;
  logic                        last_r, last_nxt;
  // Address minus window start; the top bit is the borrow.
  logic [mbdt_pkg::ADDR_W:0]   off_r, off_nxt;

  logic [QTY_W-1:0]            ei_r, ei_nxt;
  logic [mbdt_pkg::ST_W-1:0]   pend_r, pend_nxt;

  logic [QTY_W-1:0]            cnt_r, cnt_nxt;
  logic [2:0]                  bit_r, bit_nxt;
  logic [mbdt_pkg::DATA_W-1:0] acc_r, acc_nxt;

  logic [mbdt_pkg::ST_W-1:0]   hold_st_r, hold_st_nxt;
  logic [mbdt_pkg::DATA_W-1:0] hold_data_r, hold_data_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [mbdt_pkg::ST_W-1:0]   out_st_r, out_st_nxt;
  logic [mbdt_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_fire;
  logic                        slot_free;
  logic [CMP_W-1:0]            win;
  logic [CMP_W-1:0]            off_ext;
  logic                        below_start;
  logic [CMP_W-1:0]            end_sum;
  logic [CMP_W-1:0]            mw_sum;
  logic [CMP_W-1:0]            rd_sum;
  logic                        legal;
  logic                        is_multi;
  logic                        is_single;
  logic                        coil_rd;
  logic                        coil_wr;
  logic                        range_ok;
  logic                        single_ok;
  logic [mbdt_pkg::ST_W-1:0]   pend_new;
  logic                        mw_wr;
  logic [QTY_W:0]              coil_bytes;
  logic [QTY_W:0]              n_words;
  logic                        too_long;
  logic [QTY_W-1:0]            cnt_inc;
  logic                        emit;
  logic [mbdt_pkg::ST_W-1:0]   emit_st;
  logic [mbdt_pkg::DATA_W-1:0] emit_data;
  logic                        load;
  logic [mbdt_pkg::ST_W-1:0]   ld_st;
  logic [mbdt_pkg::DATA_W-1:0] ld_data;
  logic                        ld_last;

  assign in_req.ready = (state_r == S_IDLE) && !clr_busy;
  assign in_fire      = in_req.valid && in_req.ready;
  assign slot_free    = !out_valid_r || out_rsp.ready;

  assign win = (CMP_W'(cfg.data_length) > CMP_W'(STORE_DEPTH)) ?
               CMP_W'(STORE_DEPTH) : CMP_W'(cfg.data_length);

  assign below_start = off_r[mbdt_pkg::ADDR_W];
  assign off_ext     = CMP_W'(off_r[mbdt_pkg::ADDR_W-1:0]);
  assign end_sum     = off_ext + CMP_W'(qty_r);
  assign mw_sum      = off_ext + CMP_W'(ei_r);
  assign rd_sum      = off_ext + CMP_W'(cnt_r);

  assign legal     = mbdt_pkg::fc_legal(cfg.node_type, fc_r);
  assign is_multi  = (fc_r == mbdt_pkg::FC_WR_COILS) || (fc_r == mbdt_pkg::FC_WR_REGS);
  assign is_single = (fc_r == mbdt_pkg::FC_WR_COIL) || (fc_r == mbdt_pkg::FC_WR_REG);
  assign coil_rd   = (fc_r == mbdt_pkg::FC_RD_COILS) || (fc_r == mbdt_pkg::FC_RD_INPUTS);
  assign coil_wr   = (fc_r == mbdt_pkg::FC_WR_COIL) || (fc_r == mbdt_pkg::FC_WR_COILS);

  assign range_ok  = !below_start && (end_sum <= win);
  assign single_ok = !below_start && (off_ext < win);

  // A multi write is checked on its first element only.
  always_comb begin
    if (ei_r != '0) begin
      pend_new = pend_r;
    end else if (!legal) begin
      pend_new = mbdt_pkg::ST_ILL_FN;
    end else if ((qty_r == '0) || !range_ok) begin
      pend_new = mbdt_pkg::ST_ILL_ADDR;
    end else begin
      pend_new = mbdt_pkg::ST_OK;
    end
  end

  assign mw_wr = (pend_new == mbdt_pkg::ST_OK) && (ei_r < qty_r) && !below_start &&
                 (mw_sum < win);

  assign coil_bytes = ((QTY_W+1)'(qty_r) + (QTY_W+1)'(7)) >> 3;
  assign n_words    = coil_rd ? coil_bytes : (QTY_W+1)'(qty_r);
  assign too_long   = n_words > (QTY_W+1)'(mbdt_pkg::MAX_READ_RESULTS);

  assign cnt_inc = cnt_r + 1'b1;

  assign mem_waddr = is_multi ? mw_sum[AW-1:0] : off_r[AW-1:0];
  assign mem_wdata = coil_wr ? mbdt_pkg::DATA_W'(val_r != '0) : val_r;
  assign mem_raddr = rd_sum[AW-1:0];

  // Result of the check step for everything except a started read.
  always_comb begin
    emit      = 1'b0;
    emit_st   = mbdt_pkg::ST_OK;
    emit_data = '0;
    if (is_multi) begin
      emit    = last_r;
      emit_st = pend_new;
    end else if (!legal) begin
      emit    = 1'b1;
      emit_st = mbdt_pkg::ST_ILL_FN;
    end else if (is_single) begin
      emit = 1'b1;
      if (single_ok) begin
        emit_data = val_r;
      end else begin
        emit_st = mbdt_pkg::ST_ILL_ADDR;
      end
    end else if ((qty_r == '0) || !range_ok || too_long) begin
      emit    = 1'b1;
      emit_st = mbdt_pkg::ST_ILL_ADDR;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fc_nxt        = fc_r;
    qty_nxt       = qty_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    off_nxt       = off_r;
    ei_nxt        = ei_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    acc_nxt       = acc_r;
    hold_st_nxt   = hold_st_r;
    hold_data_nxt = hold_data_r;
    mem_we        = 1'b0;
    load          = 1'b0;
    ld_st         = mbdt_pkg::ST_OK;
    ld_data       = '0;
    ld_last       = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          fc_nxt    = in_req.req_type;
          qty_nxt   = in_req.quantity;
          val_nxt   = in_req.value;
          last_nxt  = in_req.last_element;
          off_nxt   = {1'b0, in_req.address} - {1'b0, cfg.start_address};
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (is_multi) begin
          mem_we   = mw_wr;
          pend_nxt = pend_new;
          ei_nxt   = (ei_r != mbdt_pkg::ELEM_MAX) ? ei_r + 1'b1 : ei_r;
          if (last_r) begin
            ei_nxt   = '0;
            pend_nxt = mbdt_pkg::ST_OK;
          end
        end else begin
          // Any other request abandons an unfinished multi write.
          ei_nxt   = '0;
          pend_nxt = mbdt_pkg::ST_OK;
          mem_we   = is_single && legal && single_ok;
        end
        if (emit) begin
          if (slot_free) begin
            load      = 1'b1;
            ld_st     = emit_st;
            ld_data   = emit_data;
            state_nxt = S_IDLE;
          end else begin
            hold_st_nxt   = emit_st;
            hold_data_nxt = emit_data;
            state_nxt     = S_EMIT;
          end
        end else if (is_multi) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = '0;
          bit_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_RD_ISS;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_st     = hold_st_r;
          ld_data   = hold_data_r;
          state_nxt = S_IDLE;
        end
      end
      S_RD_ISS: begin
        state_nxt = S_RD_ACC;
      end
      S_RD_ACC: begin
        cnt_nxt = cnt_inc;
        if (coil_rd) begin
          acc_nxt = acc_r | (mbdt_pkg::DATA_W'(mem_rdata != '0) << bit_r);
          bit_nxt = bit_r + 1'b1;
          if ((bit_r == 3'd7) || (cnt_inc == qty_r)) begin
            state_nxt = S_RD_OUT;
          end else begin
            state_nxt = S_RD_ISS;
          end
        end else begin
          acc_nxt   = mem_rdata;
          state_nxt = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_data = acc_r;
          ld_last = (cnt_r == qty_r);
          acc_nxt = '0;
          bit_nxt = '0;
          state_nxt = (cnt_r == qty_r) ? S_IDLE : S_RD_ISS;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_st_nxt    = ld_st;
      out_data_nxt  = ld_data;
      out_last_nxt  = ld_last;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ei_r        <= '0;
      pend_r      <= mbdt_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ei_r        <= ei_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fc_r        <= fc_nxt;
    qty_r       <= qty_nxt;
    val_r       <= val_nxt;
    last_r      <= last_nxt;
    off_r       <= off_nxt;
    cnt_r       <= cnt_nxt;
    bit_r       <= bit_nxt;
    acc_r       <= acc_nxt;
    hold_st_r   <= hold_st_nxt;
    hold_data_r <= hold_data_nxt;
    out_st_r    <= out_st_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_st_r;
  assign out_rsp.data_word   = out_data_r;
  assign out_rsp.last_result = out_last_r;

endmodule

FILE: rtl/core/modbus_slave_data_table_unit.sv
// A write or error result is loaded into the output register from S_CHK, or from S_EMIT
// while the output register is still full; a read goes through S_CHK, S_RD_ISS, S_RD_ACC and
// S_RD_OUT. A new request is taken only in S_IDLE, once the last one is done; a read passes
// S_RD_ISS and S_RD_ACC per register word or coil and S_RD_OUT per word or packed byte, as
// the store's read data is registered. Reset: configuration returns to holding registers,
// start 0, length 1, and the store is swept to zero, one entry per cycle, over all STORE_DEPTH
// entries (1024 by default) before any request beat; configuration writes are taken throughout.
module modbus_slave_data_table_unit #(
  parameter int STORE_DEPTH = mbdt_pkg::STORE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mbdt_in_if.sink                          in_req,
  mbdt_out_if.source                       out_rsp,
  input  logic                             cfg_we,
  input  logic [mbdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbdt_pkg::ADDR_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(STORE_DEPTH);

  mbdt_pkg::cfg_t cfg_r, cfg_nxt;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [mbdt_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [mbdt_pkg::DATA_W-1:0] mem_rdata;
  logic                        clr_busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mbdt_pkg::CFG_NODE_TYPE: cfg_nxt.node_type = cfg_wdata[mbdt_pkg::NT_W-1:0];
        mbdt_pkg::CFG_START:     cfg_nxt.start_address = cfg_wdata;
        mbdt_pkg::CFG_LENGTH:    cfg_nxt.data_length = cfg_wdata[mbdt_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_type     <= mbdt_pkg::NT_HOLD;
      cfg_r.start_address <= '0;
      cfg_r.data_length   <= mbdt_pkg::LEN_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbdt_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_data  (mem_wdata),
    .rd_addr  (mem_raddr),
    .rd_data  (mem_rdata),
    .clr_busy (clr_busy)
  );

  mbdt_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .clr_busy  (clr_busy),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
